>>> hw/rtl/rde_pkg.sv
`timescale 1ns / 1ps

package rde_pkg;

    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = 6;
    localparam int SYM_W       = 8;
    localparam int LEN_W       = 7;
    localparam int VAL_W       = 32;
    localparam int DIG_MAX     = 32;
    localparam int DIG_AW      = 5;
    localparam int CNT_W       = 6;
    localparam int MAX_RADIX   = 64;

    localparam logic [SYM_W-1:0] SYM_LOW   = 8'd32;
    localparam logic [SYM_W-1:0] SYM_HIGH  = 8'd126;
    localparam logic [SYM_W-1:0] SYM_PLUS  = 8'd43;
    localparam logic [SYM_W-1:0] SYM_MINUS = 8'd45;

    localparam logic REQ_WRITE   = 1'b0;
    localparam logic REQ_CONVERT = 1'b1;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] dividend;
        logic [LEN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] quotient;
        logic [LEN_W-1:0] remainder;
    } div_rsp_t;

endpackage

>>> hw/rtl/rde_divider.sv
`timescale 1ns / 1ps

module rde_divider
    import rde_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic [VAL_W-1:0] quo_reg, quo_next;
    logic [LEN_W-1:0] rem_reg, rem_next;
    logic [LEN_W-1:0] dsr_reg, dsr_next;
    logic [LEN_W:0]   rem_shift;
    logic [LEN_W:0]   trial;

    // one restoring step a cycle
    assign rem_shift = {rem_reg, quo_reg[VAL_W-1]};
    assign trial     = rem_shift - {1'b0, dsr_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (req.start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            quo_next = req.dividend;
            rem_next = '0;
            dsr_next = req.divisor;
        end
        else if (run_reg)
        begin
            if (rem_shift >= {1'b0, dsr_reg})
            begin
                rem_next = trial[LEN_W-1:0];
                quo_next = {quo_reg[VAL_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[LEN_W-1:0];
                quo_next = {quo_reg[VAL_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

>>> hw/rtl/rde_alpha_store.sv
`timescale 1ns / 1ps

module rde_alpha_store
    import rde_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [SYM_W-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [SYM_W-1:0]  rd_data
);

    logic [SYM_W-1:0]       mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] vld_reg;
    logic [SYM_W-1:0]       rd_data_reg;
    logic                   rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // entries never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

>>> hw/rtl/rde_digit_buf.sv
`timescale 1ns / 1ps

module rde_digit_buf
    import rde_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [DIG_AW-1:0] wr_addr,
    input  logic [ADDR_W-1:0] wr_data,
    input  logic [DIG_AW-1:0] rd_addr,
    output logic [ADDR_W-1:0] rd_data
);

    logic [ADDR_W-1:0] mem [DIG_MAX];
    logic [ADDR_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/radix_digit_emitter_core.sv
`timescale 1ns / 1ps
// write word: busy stays low, no result
// convert word: each alphabet entry is read then tested, then the bit-serial
// divider gives each digit, then each digit is read back, mapped to its symbol
// and emitted, one word at a time while busy is high
// results are strobed for one cycle each, the receiver cannot stall
// rst_n clears the alphabet to zeros and alphabet_length to 0

module radix_digit_emitter_core
    import rde_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              req_type,
    input  logic [ADDR_W-1:0] entry_index,
    input  logic [SYM_W-1:0]  entry_symbol,
    input  logic [VAL_W-1:0]  value,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [LEN_W-1:0]  cfg_data,
    output logic              result_valid,
    output logic [SYM_W-1:0]  digit_symbol,
    output logic              status,
    output logic              last
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_CHK_RD   = 3'd1;
    localparam logic [2:0] S_CHK_TST  = 3'd2;
    localparam logic [2:0] S_DIV_GO   = 3'd3;
    localparam logic [2:0] S_DIV_WAIT = 3'd4;
    localparam logic [2:0] S_EM_RD    = 3'd5;
    localparam logic [2:0] S_EM_SYM   = 3'd6;
    localparam logic [2:0] S_EM_OUT   = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [LEN_W-1:0]  alen_reg;
    logic [VAL_W-1:0]  val_reg, val_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0]  ndig_reg, ndig_next;
    logic [DIG_AW-1:0] k_reg, k_next;
    logic [127:0]      seen_reg, seen_next;
    logic              res_vld_reg, res_vld_next;
    logic [SYM_W-1:0]  res_sym_reg, res_sym_next;
    logic              res_st_reg, res_st_next;
    logic              res_last_reg, res_last_next;

    logic              accept;
    logic              alpha_wr;
    logic [ADDR_W-1:0] alpha_raddr;
    logic [SYM_W-1:0]  alpha_rdata;
    logic              dbuf_wr;
    logic [ADDR_W-1:0] dbuf_rdata;
    div_req_t          div_req;
    div_rsp_t          div_rsp;
    logic              len_bad;
    logic              sym_bad;
    logic [CNT_W-1:0]  ndig_inc;

    assign accept    = start && !busy;
    assign alpha_wr  = accept && (req_type == REQ_WRITE);
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    assign len_bad = (alen_reg < LEN_W'(2)) || (alen_reg > LEN_W'(MAX_RADIX))
                     || (alen_reg > LEN_W'(STORE_DEPTH));

    assign sym_bad = (alpha_rdata < SYM_LOW) || (alpha_rdata > SYM_HIGH)
                     || (alpha_rdata == SYM_PLUS) || (alpha_rdata == SYM_MINUS)
                     || seen_reg[alpha_rdata[6:0]];

    assign ndig_inc = ndig_reg + CNT_W'(1);

    always_comb
    begin
        case (state_reg)
            S_EM_SYM: alpha_raddr = dbuf_rdata;
            default:  alpha_raddr = idx_reg;
        endcase
    end

    assign div_req.start    = (state_reg == S_DIV_GO);
    assign div_req.dividend = val_reg;
    assign div_req.divisor  = alen_reg;
    assign dbuf_wr          = (state_reg == S_DIV_WAIT) && div_rsp.done;

    always_comb
    begin
        state_next    = state_reg;
        val_next      = val_reg;
        idx_next      = idx_reg;
        ndig_next     = ndig_reg;
        k_next        = k_reg;
        seen_next     = seen_reg;
        res_vld_next  = 1'b0;
        res_sym_next  = res_sym_reg;
        res_st_next   = res_st_reg;
        res_last_next = res_last_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (req_type == REQ_CONVERT))
                begin
                    val_next  = value;
                    idx_next  = '0;
                    ndig_next = '0;
                    seen_next = '0;
                    if (len_bad)
                    begin
                        res_vld_next  = 1'b1;
                        res_sym_next  = '0;
                        res_st_next   = STATUS_BAD;
                        res_last_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_CHK_RD;
                    end
                end
            end
            S_CHK_RD:
            begin
                state_next = S_CHK_TST;
            end
            S_CHK_TST:
            begin
                if (sym_bad)
                begin
                    res_vld_next  = 1'b1;
                    res_sym_next  = '0;
                    res_st_next   = STATUS_BAD;
                    res_last_next = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    seen_next[alpha_rdata[6:0]] = 1'b1;
                    if ({1'b0, idx_reg} == alen_reg - LEN_W'(1))
                    begin
                        state_next = S_DIV_GO;
                    end
                    else
                    begin
                        idx_next   = idx_reg + ADDR_W'(1);
                        state_next = S_CHK_RD;
                    end
                end
            end
            S_DIV_GO:
            begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    ndig_next = ndig_inc;
                    val_next  = div_rsp.quotient;
                    if ((div_rsp.quotient != '0) && (ndig_inc < CNT_W'(DIG_MAX)))
                    begin
                        state_next = S_DIV_GO;
                    end
                    else
                    begin
                        k_next     = ndig_reg[DIG_AW-1:0];
                        state_next = S_EM_RD;
                    end
                end
            end
            S_EM_RD:
            begin
                state_next = S_EM_SYM;
            end
            S_EM_SYM:
            begin
                state_next = S_EM_OUT;
            end
            S_EM_OUT:
            begin
                res_vld_next  = 1'b1;
                res_sym_next  = alpha_rdata;
                res_st_next   = STATUS_OK;
                res_last_next = (k_reg == '0);
                if (k_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    k_next     = k_reg - DIG_AW'(1);
                    state_next = S_EM_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            alen_reg    <= '0;
            seen_reg    <= '0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            seen_reg    <= seen_next;
            res_vld_reg <= res_vld_next;
            if (cfg_valid && cfg_ready)
            begin
                alen_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg      <= val_next;
        idx_reg      <= idx_next;
        ndig_reg     <= ndig_next;
        k_reg        <= k_next;
        res_sym_reg  <= res_sym_next;
        res_st_reg   <= res_st_next;
        res_last_reg <= res_last_next;
    end

    rde_alpha_store u_alpha_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (alpha_wr),
        .wr_addr (entry_index),
        .wr_data (entry_symbol),
        .rd_addr (alpha_raddr),
        .rd_data (alpha_rdata)
    );

    rde_digit_buf u_digit_buf (
        .clk     (clk),
        .wr_en   (dbuf_wr),
        .wr_addr (ndig_reg[DIG_AW-1:0]),
        .wr_data (div_rsp.remainder[ADDR_W-1:0]),
        .rd_addr (k_reg),
        .rd_data (dbuf_rdata)
    );

    rde_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign result_valid = res_vld_reg;
    assign digit_symbol = res_sym_reg;
    assign status       = res_st_reg;
    assign last         = res_last_reg;

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
    import rde_pkg::*;

    localparam int TOTAL_WORDS    = 360;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 64;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int REPORT_CAP     = 200;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             status;
        logic             is_last;
    } glyph_t;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              start        = 1'b0;
    logic              busy;
    logic              req_type     = REQ_WRITE;
    logic [ADDR_W-1:0] entry_index  = '0;
    logic [SYM_W-1:0]  entry_symbol = '0;
    logic [VAL_W-1:0]  value        = '0;
    logic              cfg_valid    = 1'b0;
    logic              cfg_ready;
    logic [LEN_W-1:0]  cfg_data     = '0;
    logic              result_valid;
    logic [SYM_W-1:0]  digit_symbol;
    logic              status;
    logic              last;

    glyph_t           pending_glyphs [$];
    logic [SYM_W-1:0] model_alphabet [STORE_DEPTH];
    logic [LEN_W-1:0] model_radix = '0;
    logic [SYM_W-1:0] plan_alphabet  [STORE_DEPTH];
    int               fail_count   = 0;
    int               quiet_cycles = 0;
    int               words_sent   = 0;
    int               burst_left   = 0;

    radix_digit_emitter_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .entry_index  (entry_index),
        .entry_symbol (entry_symbol),
        .value        (value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .digit_symbol (digit_symbol),
        .status       (status),
        .last         (last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            model_alphabet[i] = '0;
            plan_alphabet[i]  = '0;
        end
    end

    function automatic logic alphabet_usable();
        int n;
        int i;
        int j;
        logic [SYM_W-1:0] c;
        n = model_radix;
        if (n < 2 || n > MAX_RADIX || n > STORE_DEPTH)
            return 1'b0;
        for (i = 0; i < n; i++)
        begin
            c = model_alphabet[i];
            if (c < SYM_LOW || c > SYM_HIGH || c == SYM_PLUS || c == SYM_MINUS)
                return 1'b0;
            for (j = i + 1; j < n; j++)
                if (model_alphabet[j] == c)
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic predict_conversion(input logic [VAL_W-1:0] number);
        logic [VAL_W-1:0] rest;
        logic [VAL_W-1:0] base;
        logic [ADDR_W-1:0] digits [DIG_MAX];
        int n;
        int k;
        if (!alphabet_usable())
        begin
            pending_glyphs.push_back('{symbol: '0, status: STATUS_BAD, is_last: 1'b1});
            return;
        end
        base = VAL_W'(model_radix);
        rest = number;
        n = 0;
        do
        begin
            digits[n] = ADDR_W'(rest % base);
            rest = rest / base;
            n++;
        end
        while (rest != 0 && n < DIG_MAX);
        for (k = n - 1; k >= 0; k--)
            pending_glyphs.push_back('{symbol: model_alphabet[digits[k]], status: STATUS_OK,
                                       is_last: (k == 0)});
    endtask

    task automatic note_mismatch(input string what, input logic [SYM_W-1:0] want,
                                 input logic [SYM_W-1:0] got);
        fail_count++;
        if (fail_count <= REPORT_CAP)
            $display("%0t mismatch on %s: expected %0h, actual %0h", $time, what, want, got);
    endtask

    task automatic check_glyph();
        glyph_t want;
        if (pending_glyphs.size() == 0)
        begin
            fail_count++;
            if (fail_count <= REPORT_CAP)
                $display("%0t unexpected result: expected none, actual symbol %0h status %0b last %0b",
                         $time, digit_symbol, status, last);
            return;
        end
        want = pending_glyphs.pop_front();
        if (digit_symbol !== want.symbol)
            note_mismatch("digit_symbol", want.symbol, digit_symbol);
        if (status !== want.status)
            note_mismatch("status", SYM_W'(want.status), SYM_W'(status));
        if (last !== want.is_last)
            note_mismatch("last", SYM_W'(want.is_last), SYM_W'(last));
    endtask

    // scoreboard and prediction, all sampled on the pre-edge values
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
                check_glyph();
            if (start && !busy)
            begin
                if (req_type == REQ_WRITE)
                    model_alphabet[entry_index] = entry_symbol;
                else
                    predict_conversion(value);
            end
            if (cfg_valid && cfg_ready)
                model_radix = cfg_data;
            if (result_valid || (start && !busy) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("radix_digit_emitter_core verification failed");
        $finish;
    end

    task automatic send_word(input logic kind, input logic [ADDR_W-1:0] idx,
                             input logic [SYM_W-1:0] sym, input logic [VAL_W-1:0] val);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 3) != 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
        burst_left--;
        start        <= 1'b1;
        req_type     <= kind;
        entry_index  <= idx;
        entry_symbol <= sym;
        value        <= val;
        if (kind == REQ_WRITE)
            plan_alphabet[idx] = sym;
        do @(posedge clk); while (busy);
        words_sent++;
    endtask

    task automatic write_entry(input logic [ADDR_W-1:0] idx, input logic [SYM_W-1:0] sym);
        send_word(REQ_WRITE, idx, sym, $urandom);
    endtask

    task automatic convert(input logic [VAL_W-1:0] number);
        send_word(REQ_CONVERT, ADDR_W'($urandom), SYM_W'($urandom), number);
    endtask

    // block drained before the length register changes
    task automatic set_radix(input logic [LEN_W-1:0] len);
        start <= 1'b0;
        do @(posedge clk); while (pending_glyphs.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [SYM_W-1:0] fresh_symbol();
        logic [SYM_W-1:0] s;
        logic clash;
        int i;
        do
        begin
            s = SYM_W'($urandom_range(SYM_LOW, SYM_HIGH));
            clash = (s == SYM_PLUS) || (s == SYM_MINUS);
            for (i = 0; i < STORE_DEPTH; i++)
                if (plan_alphabet[i] == s)
                    clash = 1'b1;
        end
        while (clash);
        return s;
    endfunction

    function automatic logic [VAL_W-1:0] pick_value(input int len);
        logic [63:0] p;
        int k;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3:
            begin
                p = 64'd1;
                k = $urandom_range(1, 31);
                if (len >= 2 && len <= MAX_RADIX)
                    while (k > 0 && p * len <= 64'hFFFF_FFFF)
                    begin
                        p = p * len;
                        k--;
                    end
                return p[VAL_W-1:0] - VAL_W'($urandom_range(0, 1));
            end
            default: return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    task automatic test_unloaded_alphabet();
        convert(32'd1234);
        set_radix(LEN_W'(2));
        convert(32'd7);
    endtask

    task automatic test_alphabet_rules();
        write_entry(6'd0, 8'h30);
        write_entry(6'd1, 8'h31);
        convert(32'd5);
        convert(32'd0);
        write_entry(6'd1, SYM_PLUS);
        convert(32'd5);
        write_entry(6'd1, SYM_MINUS);
        convert(32'd5);
        write_entry(6'd1, SYM_LOW - 8'd1);
        convert(32'd5);
        write_entry(6'd1, SYM_HIGH + 8'd1);
        convert(32'd5);
        write_entry(6'd1, 8'h30);
        convert(32'd5);
        // printable edges, longest digit string
        write_entry(6'd0, SYM_LOW);
        write_entry(6'd1, SYM_HIGH);
        convert(32'hFFFF_FFFF);
    endtask

    task automatic test_length_limits();
        set_radix(LEN_W'(1));
        convert(32'd3);
        set_radix(LEN_W'(MAX_RADIX + 1));
        convert(32'd3);
        set_radix('1);
        convert(32'd3);
    endtask

    task automatic test_field_extremes();
        send_word(REQ_WRITE, '1, '1, '1);
        set_radix(LEN_W'(2));
        send_word(REQ_CONVERT, '1, '1, '0);
    endtask

    task automatic test_random_conversions();
        int len;
        int slot;
        int broken_slot;
        logic [SYM_W-1:0] bad_sym;
        broken_slot = -1;
        for (int i = 0; i < STORE_DEPTH; i++)
            write_entry(ADDR_W'(i), fresh_symbol());
        while (words_sent < TOTAL_WORDS)
        begin
            if (broken_slot >= 0)
            begin
                write_entry(ADDR_W'(broken_slot), fresh_symbol());
                broken_slot = -1;
            end
            case ($urandom_range(0, 19))
                0: len = $urandom_range(0, 1);
                1: len = $urandom_range(MAX_RADIX + 1, 127);
                2: len = MAX_RADIX;
                3: len = 2;
                default: len = $urandom_range(2, MAX_RADIX);
            endcase
            set_radix(LEN_W'(len));
            repeat ($urandom_range(0, 3))
                write_entry(ADDR_W'($urandom), fresh_symbol());
            if ($urandom_range(0, 6) == 0)
            begin
                if (len >= 2 && len <= MAX_RADIX)
                    slot = $urandom_range(0, len - 1);
                else
                    slot = $urandom_range(0, STORE_DEPTH - 1);
                case ($urandom_range(0, 4))
                    0: bad_sym = SYM_W'($urandom_range(0, 255));
                    1: bad_sym = SYM_PLUS;
                    2: bad_sym = SYM_MINUS;
                    3: bad_sym = plan_alphabet[(len >= 2 && len <= MAX_RADIX) ?
                                               $urandom_range(0, len - 1) : 0];
                    default: bad_sym = ($urandom_range(0, 1) != 0) ? SYM_LOW - 8'd1
                                                                    : SYM_HIGH + 8'd1;
                endcase
                write_entry(ADDR_W'(slot), bad_sym);
                broken_slot = slot;
            end
            repeat ($urandom_range(3, 8))
                convert(pick_value(len));
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_unloaded_alphabet();
        test_alphabet_rules();
        test_length_limits();
        test_field_extremes();
        test_random_conversions();
        start <= 1'b0;
        do @(posedge clk); while (pending_glyphs.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_glyphs.size() != 0)
        begin
            fail_count++;
            $display("%0t %0d results still outstanding: expected 0, actual %0d",
                     $time, pending_glyphs.size(), pending_glyphs.size());
        end
        if (fail_count == 0)
            $display("radix_digit_emitter_core verification clean");
        else
            $display("radix_digit_emitter_core verification failed");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/rde_pkg.sv
hw/rtl/rde_divider.sv
hw/rtl/rde_alpha_store.sv
hw/rtl/rde_digit_buf.sv
hw/rtl/radix_digit_emitter_core.sv
test/tb.sv
